// ===== src/circuit_breaker_fsm_defines.svh =====
// Assertion macros used by the breaker checker.
`ifndef CIRCUIT_BREAKER_FSM_DEFINES_SVH
`define CIRCUIT_BREAKER_FSM_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CBF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("breaker check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CBF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("breaker check failed");

`endif

// ===== src/cbf_pkg.sv =====
package cbf_pkg;

  typedef enum logic [1:0] {
    MODE_CLOSED = 2'd0,
    MODE_OPEN   = 2'd1,
    MODE_HALF   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_SUCCESS = 2'd1,
    OP_FAILURE = 2'd2,
    OP_RESET   = 2'd3
  } op_e;

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_FAILURE_LIMIT = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SUCCESS_LIMIT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_OPEN_TIMEOUT  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PROBE_LIMIT   = 3'd3;

  localparam logic [15:0] FAILURE_LIMIT_RST = 16'd5;
  localparam logic [15:0] SUCCESS_LIMIT_RST = 16'd2;
  localparam logic [31:0] OPEN_TIMEOUT_RST  = 32'd30000;
  localparam logic [15:0] PROBE_LIMIT_RST   = 16'd3;

  typedef struct packed {
    logic [15:0] failure_limit;
    logic [15:0] success_limit;
    logic [31:0] open_timeout;
    logic [15:0] probe_limit;
  } cfg_t;

  typedef struct packed {
    logic        granted;
    mode_e       breaker_state;
    logic [31:0] success_total;
    logic [31:0] failure_total;
    logic [31:0] reject_total;
  } result_t;

  function automatic logic [15:0] sat16(input logic [15:0] v);
    sat16 = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [31:0] sat32(input logic [31:0] v);
    sat32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

// ===== src/circuit_breaker_fsm.sv =====
// An accepted item passes the input register, then the result register.
// Throughput: one item per cycle when out_ready_i does not stall the output;
// the breaker state updates as an item moves from input to result register.
// Reset (rst_ni low, asynchronous): breaker closed, runs and totals zero,
// limits back to 5 / 2 / 30000 ms / 3, both stages empty.
module circuit_breaker_fsm
  import cbf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic [31:0]        now_ms_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               granted_o,
  output logic [1:0]         breaker_state_o,
  output logic [31:0]        success_total_o,
  output logic [31:0]        failure_total_o,
  output logic [31:0]        reject_total_o
);

  cfg_t        cfg;
  result_t     res_d, res_q;
  logic        in_valid_q;
  logic [1:0]  op_q;
  logic [31:0] now_q;
  logic        out_valid_q;
  logic        out_free;
  logic        adv;

  assign out_free   = !out_valid_q || out_ready_i;
  assign adv        = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  cbf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  cbf_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .op_i   (op_q),
    .now_i  (now_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (out_free) out_valid_q <= in_valid_q;
    end
  end

  // hold payload while stalled
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q  <= operation_i;
      now_q <= now_ms_i;
    end
    if (adv) res_q <= res_d;
  end

  assign out_valid_o     = out_valid_q;
  assign granted_o       = res_q.granted;
  assign breaker_state_o = res_q.breaker_state;
  assign success_total_o = res_q.success_total;
  assign failure_total_o = res_q.failure_total;
  assign reject_total_o  = res_q.reject_total;

endmodule

// ===== src/cbf_cfg.sv =====
module cbf_cfg
  import cbf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FAILURE_LIMIT: cfg_d.failure_limit = cfg_data_i[15:0];
        CFG_SUCCESS_LIMIT: cfg_d.success_limit = cfg_data_i[15:0];
        CFG_OPEN_TIMEOUT:  cfg_d.open_timeout  = cfg_data_i;
        CFG_PROBE_LIMIT:   cfg_d.probe_limit   = cfg_data_i[15:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.failure_limit <= FAILURE_LIMIT_RST;
      cfg_q.success_limit <= SUCCESS_LIMIT_RST;
      cfg_q.open_timeout  <= OPEN_TIMEOUT_RST;
      cfg_q.probe_limit   <= PROBE_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/cbf_core.sv =====
module cbf_core
  import cbf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic [1:0]  op_i,
  input  logic [31:0] now_i,
  input  cfg_t        cfg_i,
  output result_t     res_o
);

  mode_e       mode_q, mode_d;
  logic [15:0] fail_run_q, fail_run_d;
  logic [15:0] success_run_q, success_run_d;
  logic [15:0] probe_q, probe_d;
  logic [31:0] changed_q, changed_d;
  logic [31:0] success_cnt_q, success_cnt_d;
  logic [31:0] failure_cnt_q, failure_cnt_d;
  logic [31:0] reject_cnt_q, reject_cnt_d;

  logic [15:0] fail_inc;
  logic [15:0] success_inc;
  logic [31:0] elapsed;
  logic        timeout_hit;
  logic        close_hit;
  logic        trip_hit;
  logic        grant;

  assign fail_inc    = sat16(fail_run_q);
  assign success_inc = sat16(success_run_q);
  assign elapsed     = now_i - changed_q;
  assign timeout_hit = (mode_q == MODE_OPEN) && (elapsed >= cfg_i.open_timeout);
  assign close_hit   = (mode_q == MODE_HALF) && (success_inc >= cfg_i.success_limit);
  assign trip_hit    = (mode_q == MODE_HALF) ||
                       ((mode_q == MODE_CLOSED) && (fail_inc >= cfg_i.failure_limit));

  // next state
  always_comb begin
    mode_d = mode_q;
    case (op_e'(op_i))
      OP_REQUEST: if (timeout_hit) mode_d = MODE_HALF;
      OP_SUCCESS: if (close_hit) mode_d = MODE_CLOSED;
      OP_FAILURE: if (trip_hit) mode_d = MODE_OPEN;
      OP_RESET:   mode_d = MODE_CLOSED;
      default:    mode_d = mode_q;
    endcase
  end

  // runs, probe count, change time, totals and grant
  always_comb begin
    grant         = 1'b0;
    fail_run_d    = fail_run_q;
    success_run_d = success_run_q;
    probe_d       = probe_q;
    changed_d     = changed_q;
    success_cnt_d = success_cnt_q;
    failure_cnt_d = failure_cnt_q;
    reject_cnt_d  = reject_cnt_q;
    case (op_e'(op_i))
      OP_REQUEST: begin
        case (mode_q)
          MODE_CLOSED: grant = 1'b1;
          MODE_OPEN: begin
            if (timeout_hit) begin
              grant         = 1'b1;
              probe_d       = '0;
              success_run_d = '0;
              changed_d     = now_i;
            end else begin
              reject_cnt_d = sat32(reject_cnt_q);
            end
          end
          MODE_HALF: begin
            if (probe_q < cfg_i.probe_limit) begin
              grant   = 1'b1;
              probe_d = sat16(probe_q);
            end else begin
              reject_cnt_d = sat32(reject_cnt_q);
            end
          end
          default: grant = 1'b0;
        endcase
      end
      OP_SUCCESS: begin
        success_cnt_d = sat32(success_cnt_q);
        fail_run_d    = '0;
        if (close_hit) begin
          success_run_d = '0;
          probe_d       = '0;
          changed_d     = now_i;
        end else begin
          success_run_d = success_inc;
        end
      end
      OP_FAILURE: begin
        failure_cnt_d = sat32(failure_cnt_q);
        success_run_d = '0;
        if (trip_hit) begin
          fail_run_d = '0;
          changed_d  = now_i;
        end else begin
          fail_run_d = fail_inc;
        end
      end
      OP_RESET: begin
        fail_run_d    = '0;
        success_run_d = '0;
        probe_d       = '0;
        changed_d     = now_i;
      end
      default: grant = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_CLOSED;
      fail_run_q    <= '0;
      success_run_q <= '0;
      probe_q       <= '0;
      changed_q     <= '0;
      success_cnt_q <= '0;
      failure_cnt_q <= '0;
      reject_cnt_q  <= '0;
    end else if (adv_i) begin
      mode_q        <= mode_d;
      fail_run_q    <= fail_run_d;
      success_run_q <= success_run_d;
      probe_q       <= probe_d;
      changed_q     <= changed_d;
      success_cnt_q <= success_cnt_d;
      failure_cnt_q <= failure_cnt_d;
      reject_cnt_q  <= reject_cnt_d;
    end
  end

  assign res_o.granted       = grant;
  assign res_o.breaker_state = mode_d;
  assign res_o.success_total = success_cnt_d;
  assign res_o.failure_total = failure_cnt_d;
  assign res_o.reject_total  = reject_cnt_d;

endmodule

// ===== src/cbf_checker.sv =====
`include "circuit_breaker_fsm_defines.svh"

module cbf_checker
  import cbf_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        granted_o,
  input logic [1:0]  breaker_state_o,
  input logic [31:0] success_total_o,
  input logic [31:0] failure_total_o,
  input logic [31:0] reject_total_o
);

  logic        out_stall;
  logic        grant_shown;
  logic        in_acc;
  logic [98:0] out_bus;

  assign out_stall   = out_valid_o && !out_ready_i;
  assign grant_shown = out_valid_o && granted_o;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_bus     = {granted_o, breaker_state_o, success_total_o, failure_total_o,
                        reject_total_o};

  `CBF_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable(out_bus))
  `CBF_ASSERT_NOW(a_grant_not_open, grant_shown, breaker_state_o != MODE_OPEN)
  `CBF_ASSERT_NOW(a_ready_when_empty, !out_valid_o, in_ready_o)
  `CBF_ASSERT_NOW(a_result_from_item, $rose(out_valid_o), $past(in_acc, 2))

endmodule

bind circuit_breaker_fsm cbf_checker u_cbf_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import cbf_pkg::*;

  localparam int unsigned MaxCycles = 200000;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_FIRST = CFG_PROBE_LIMIT + 1'b1;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [31:0]        cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [1:0]         operation_i = OP_REQUEST;
  logic [31:0]        now_ms_i    = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               granted_o;
  logic [1:0]         breaker_state_o;
  logic [31:0]        success_total_o;
  logic [31:0]        failure_total_o;
  logic [31:0]        reject_total_o;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          error_count   = 0;
  int unsigned cycle_count   = 0;

  cfg_t        lim_cfg;
  mode_e       brk_mode;
  logic [15:0] fail_run_q;
  logic [15:0] succ_run_q;
  logic [15:0] probe_cnt_q;
  logic [31:0] changed_at_q;
  logic [31:0] succ_total_q;
  logic [31:0] fail_total_q;
  logic [31:0] rej_total_q;
  result_t     pending_results[$];

  always #5 clk_i = ~clk_i;

  circuit_breaker_fsm u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .now_ms_i        (now_ms_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .granted_o       (granted_o),
    .breaker_state_o (breaker_state_o),
    .success_total_o (success_total_o),
    .failure_total_o (failure_total_o),
    .reject_total_o  (reject_total_o)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MaxCycles) begin
      $display("FAIL circuit_breaker_fsm");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic logic [15:0] bump16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [31:0] bump32(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  task automatic enter_open(input logic [31:0] now);
    brk_mode     = MODE_OPEN;
    fail_run_q   = '0;
    succ_run_q   = '0;
    changed_at_q = now;
  endtask

  task automatic enter_closed(input logic [31:0] now);
    brk_mode     = MODE_CLOSED;
    fail_run_q   = '0;
    succ_run_q   = '0;
    probe_cnt_q  = '0;
    changed_at_q = now;
  endtask

  task automatic predict_event(input op_e op, input logic [31:0] now);
    result_t     res;
    logic [31:0] elapsed;
    res.granted = 1'b0;
    case (op)
      OP_REQUEST: begin
        if (brk_mode == MODE_CLOSED) begin
          res.granted = 1'b1;
        end else if (brk_mode == MODE_OPEN) begin
          elapsed = now - changed_at_q;
          if (elapsed >= lim_cfg.open_timeout) begin
            brk_mode     = MODE_HALF;
            probe_cnt_q  = '0;
            succ_run_q   = '0;
            changed_at_q = now;
            res.granted  = 1'b1;
          end else begin
            rej_total_q = bump32(rej_total_q);
          end
        end else begin
          if (probe_cnt_q < lim_cfg.probe_limit) begin
            probe_cnt_q = bump16(probe_cnt_q);
            res.granted = 1'b1;
          end else begin
            rej_total_q = bump32(rej_total_q);
          end
        end
      end
      OP_SUCCESS: begin
        succ_total_q = bump32(succ_total_q);
        succ_run_q   = bump16(succ_run_q);
        fail_run_q   = '0;
        if (brk_mode == MODE_HALF && succ_run_q >= lim_cfg.success_limit) begin
          enter_closed(now);
        end
      end
      OP_FAILURE: begin
        fail_total_q = bump32(fail_total_q);
        fail_run_q   = bump16(fail_run_q);
        succ_run_q   = '0;
        if (brk_mode == MODE_CLOSED) begin
          if (fail_run_q >= lim_cfg.failure_limit) enter_open(now);
        end else if (brk_mode == MODE_HALF) begin
          enter_open(now);
        end
      end
      default: begin
        enter_closed(now);
      end
    endcase
    res.breaker_state = brk_mode;
    res.success_total = succ_total_q;
    res.failure_total = fail_total_q;
    res.reject_total  = rej_total_q;
    pending_results.push_back(res);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual state %0d granted %0b",
                 $time, breaker_state_o, granted_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("granted", 32'(want.granted), 32'(granted_o));
        check_field("breaker_state", 32'(want.breaker_state), 32'(breaker_state_o));
        check_field("success_total", want.success_total, success_total_o);
        check_field("failure_total", want.failure_total, failure_total_o);
        check_field("reject_total", want.reject_total, reject_total_o);
      end
    end
  end

  task automatic send_event(input op_e op, input logic [31:0] now);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    operation_i <= op;
    now_ms_i    <= now;
    do @(posedge clk_i); while (!in_ready_o);
    predict_event(op, now);
  endtask

  // drop valid and wait until every expected result has come back
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_FAILURE_LIMIT: lim_cfg.failure_limit = value[15:0];
      CFG_SUCCESS_LIMIT: lim_cfg.success_limit = value[15:0];
      CFG_OPEN_TIMEOUT:  lim_cfg.open_timeout  = value;
      CFG_PROBE_LIMIT:   lim_cfg.probe_limit   = value[15:0];
      default: ;
    endcase
  endtask

  task automatic test_default_limits();
    int k;
    send_event(OP_REQUEST, 32'd1000);
    for (k = 1; k <= 5; k++) send_event(OP_FAILURE, 32'd1000 + k);
    send_event(OP_SUCCESS, 32'd1006);
    send_event(OP_REQUEST, 32'd1005 + 32'd29999);
    send_event(OP_REQUEST, 32'd1005 + 32'd30000);
    for (k = 0; k < 4; k++) send_event(OP_REQUEST, 32'd31010 + k);
    send_event(OP_SUCCESS, 32'd31020);
    send_event(OP_SUCCESS, 32'd31021);
    settle();
  endtask

  task automatic test_zero_limits();
    int k;
    write_reg(CFG_FAILURE_LIMIT, 32'hFFFF_0000);
    write_reg(CFG_SUCCESS_LIMIT, 32'hFFFF_0000);
    write_reg(CFG_OPEN_TIMEOUT, 32'd0);
    write_reg(CFG_PROBE_LIMIT, 32'hFFFF_0000);
    // writes past the last register must leave the limits alone
    for (k = CFG_UNUSED_FIRST; k < (1 << CfgIdxW); k++) begin
      write_reg(k[CfgIdxW-1:0], $urandom());
    end
    send_event(OP_FAILURE, 32'd100);
    send_event(OP_REQUEST, 32'd100);
    send_event(OP_REQUEST, 32'd101);
    send_event(OP_SUCCESS, 32'd102);
    settle();
  endtask

  task automatic test_extreme_limits();
    write_reg(CFG_FAILURE_LIMIT, 32'hFFFF_0000);
    write_reg(CFG_SUCCESS_LIMIT, 32'hFFFF_FFFF);
    write_reg(CFG_OPEN_TIMEOUT, 32'hFFFF_FFFF);
    write_reg(CFG_PROBE_LIMIT, 32'hFFFF_FFFF);
    send_event(OP_RESET, 32'hFFFF_FFF0);
    send_event(OP_FAILURE, 32'hFFFF_FFF8);
    send_event(OP_REQUEST, 32'hFFFF_FFF6);
    send_event(OP_REQUEST, 32'hFFFF_FFF7);
    send_event(OP_REQUEST, 32'h0000_0000);
    send_event(OP_SUCCESS, 32'h0000_0001);
    send_event(OP_FAILURE, 32'h0000_0002);
    settle();
    write_reg(CFG_FAILURE_LIMIT, 32'hFFFF_FFFF);
    send_event(OP_RESET, 32'd5);
    send_event(OP_FAILURE, 32'd6);
    settle();
  endtask

  task automatic test_random_traffic(input int n_items, input int send_pct,
                                     input int recv_pct);
    int          chunk;
    int          i;
    int          pick;
    op_e         op;
    logic [31:0] clock_ms;
    logic [31:0] now;
    logic [31:0] noise;
    logic [15:0] lim16;
    logic [31:0] lim32;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (chunk = 0; chunk < 3; chunk++) begin
      settle();
      noise = $urandom();
      case ($urandom_range(0, 9))
        0: lim16 = '0;
        1: lim16 = 16'hFFFF;
        2: lim16 = 16'($urandom());
        default: lim16 = 16'($urandom_range(1, 4));
      endcase
      write_reg(CFG_FAILURE_LIMIT, {noise[31:16], lim16});
      case ($urandom_range(0, 9))
        0: lim16 = '0;
        1: lim16 = 16'hFFFF;
        2: lim16 = 16'($urandom());
        default: lim16 = 16'($urandom_range(1, 3));
      endcase
      write_reg(CFG_SUCCESS_LIMIT, {noise[15:0], lim16});
      case ($urandom_range(0, 9))
        0: lim16 = '0;
        1: lim16 = 16'hFFFF;
        2: lim16 = 16'($urandom());
        default: lim16 = 16'($urandom_range(1, 3));
      endcase
      write_reg(CFG_PROBE_LIMIT, {noise[23:8], lim16});
      case ($urandom_range(0, 9))
        0: lim32 = '0;
        1: lim32 = 32'hFFFF_FFFF;
        2: lim32 = $urandom();
        default: lim32 = $urandom_range(1, 40);
      endcase
      write_reg(CFG_OPEN_TIMEOUT, lim32);
      if ($urandom_range(0, 1) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      else clock_ms = $urandom();
      for (i = 0; i < n_items / 3; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) op = OP_REQUEST;
        else if (pick < 65) op = OP_SUCCESS;
        else if (pick < 97) op = OP_FAILURE;
        else op = OP_RESET;
        if ($urandom_range(0, 19) == 0) begin
          now = $urandom();
        end else begin
          clock_ms = clock_ms + $urandom_range(0, 12);
          now      = clock_ms;
        end
        send_event(op, now);
      end
    end
    settle();
  endtask

  initial begin
    lim_cfg = '{failure_limit: FAILURE_LIMIT_RST, success_limit: SUCCESS_LIMIT_RST,
                open_timeout: OPEN_TIMEOUT_RST, probe_limit: PROBE_LIMIT_RST};
    brk_mode      = MODE_CLOSED;
    fail_run_q    = '0;
    succ_run_q    = '0;
    probe_cnt_q   = '0;
    changed_at_q  = '0;
    succ_total_q  = '0;
    fail_total_q  = '0;
    rej_total_q   = '0;
    send_idle_pct = 37;
    recv_idle_pct = 71;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_default_limits();
    test_zero_limits();
    test_extreme_limits();
    test_random_traffic(450, 37, 71);
    test_random_traffic(450, 71, 37);
    test_random_traffic(450, 0, 0);

    settle();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS circuit_breaker_fsm");
    end else begin
      $display("FAIL circuit_breaker_fsm");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/cbf_pkg.sv
src/cbf_cfg.sv
src/cbf_core.sv
src/circuit_breaker_fsm.sv
src/cbf_checker.sv
verif/tb_top.sv
